FILE: rtl/k2p_pair_distance_defines.svh
// ----------------------------------------------------------------------------
// k2p_pair_distance_defines
// Assertion macros shared by the pair distance block.
// ----------------------------------------------------------------------------
`ifndef K2P_PAIR_DISTANCE_DEFINES_SVH
`define K2P_PAIR_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define K2P_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define K2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/k2p_pkg.sv
// ----------------------------------------------------------------------------
// k2p_pkg
// Types and constants of the pair distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package k2p_pkg;

	localparam int unsigned MAX_COLUMNS = 65535;
	localparam logic [15:0] COUNT_CAP = (MAX_COLUMNS < 65535) ? 16'(MAX_COLUMNS) : 16'hFFFF;
	localparam logic [21:0] DIST_MAX = 22'h3FFFFF;
	localparam int LOG_FRAC = 24;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;

	localparam logic [1:0] SEL_N = 2'd0;
	localparam logic [1:0] SEL_A = 2'd1;
	localparam logic [1:0] SEL_B = 2'd2;

	typedef struct packed {
		logic [7:0] base_a;
		logic [7:0] base_b;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [21:0] distance;
		logic        undefined;
		logic [15:0] transitions;
		logic [15:0] transversions;
	} result_t;

	typedef struct packed {
		logic       count;
		logic       prep;
		logic       load;
		logic       iter;
		logic       acc;
		logic       emit;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic undef;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/k2p_datapath.sv
// ----------------------------------------------------------------------------
// k2p_datapath
// Column counters, argument registers, shared log2 unit and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module k2p_datapath
	import k2p_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire item_t       item,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	output result_t          result
);

	logic [15:0] align_q;
	logic [15:0] ts_q;
	logic [15:0] tv_q;
	logic signed [18:0] a_q;
	logic signed [17:0] b_q;
	logic [31:0] m_q;
	logic [3:0]  e_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [31:0] s_q;

	logic        is_ts;
	logic        is_tv;
	logic [15:0] x;
	logic [3:0]  e;
	logic [63:0] prod;
	logic [32:0] sq;
	logic [31:0] lg;
	logic [32:0] rnd;

	always_comb begin
		is_ts = (item.base_a == CH_A && item.base_b == CH_G) ||
			(item.base_a == CH_G && item.base_b == CH_A) ||
			(item.base_a == CH_C && item.base_b == CH_T) ||
			(item.base_a == CH_T && item.base_b == CH_C);
		is_tv = (item.base_a == CH_A && item.base_b == CH_T) ||
			(item.base_a == CH_T && item.base_b == CH_A) ||
			(item.base_a == CH_G && item.base_b == CH_C) ||
			(item.base_a == CH_C && item.base_b == CH_G);
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_N:   x = align_q;
			SEL_A:   x = a_q[15:0];
			default: x = b_q[15:0];
		endcase
		e = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (x[i]) begin
				e = 4'(i);
			end
		end
	end

	assign prod = 64'(m_q) * 64'(m_q);
	assign sq = prod[63:31];
	assign lg = {4'b0, e_q, frac_q};
	assign rnd = 33'(s_q) + 33'd512;
	assign stat.undef = a_q[18] || (a_q == '0) || b_q[17] || (b_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= 16'd1;
			ts_q <= '0;
			tv_q <= '0;
		end else begin
			if (cfg_we) begin
				align_q <= cfg_wdata;
			end
			if (cmd.count) begin
				if (is_ts && ts_q < COUNT_CAP) begin
					ts_q <= ts_q + 16'd1;
				end else if (is_tv && tv_q < COUNT_CAP) begin
					tv_q <= tv_q + 16'd1;
				end
			end else if (cmd.emit) begin
				ts_q <= '0;
				tv_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			a_q <= $signed({3'b0, align_q}) - $signed({2'b0, ts_q, 1'b0}) -
				$signed({3'b0, tv_q});
			b_q <= $signed({2'b0, align_q}) - $signed({1'b0, tv_q, 1'b0});
			s_q <= '0;
		end
		if (cmd.load) begin
			e_q <= e;
			m_q <= 32'(x) << (5'd31 - 5'(e));
			frac_q <= '0;
		end
		if (cmd.iter) begin
			if (sq[32]) begin
				m_q <= sq[32:1];
			end else begin
				m_q <= sq[31:0];
			end
			frac_q <= {frac_q[LOG_FRAC-2:0], sq[32]};
		end
		if (cmd.acc) begin
			unique case (cmd.sel)
				SEL_N:   s_q <= s_q + (lg << 1) + lg;
				SEL_A:   s_q <= s_q - (lg << 1);
				default: s_q <= s_q - lg;
			endcase
		end
		if (cmd.emit) begin
			result.distance <= stat.undef ? DIST_MAX : rnd[31:10];
			result.undefined <= stat.undef;
			result.transitions <= ts_q;
			result.transversions <= tv_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/k2p_ctrl.sv
// ----------------------------------------------------------------------------
// k2p_ctrl
// Sequencer for counting, argument setup and the three log2 evaluations.
// ----------------------------------------------------------------------------
`default_nettype none

module k2p_ctrl
	import k2p_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic  last,
	input  wire stat_t stat,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_LOAD, ST_ITER, ST_ACC, ST_EMIT} state_t;

	state_t     state_q;
	logic [4:0] step_q;
	logic [1:0] sel_q;

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		unique case (state_q)
			ST_IDLE: cmd.count = start;
			ST_PREP: cmd.prep = 1'b1;
			ST_LOAD: cmd.load = !stat.undef;
			ST_ITER: cmd.iter = 1'b1;
			ST_ACC:  cmd.acc = 1'b1;
			ST_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			sel_q <= SEL_N;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && last) begin
						state_q <= ST_PREP;
						busy <= 1'b1;
					end
				end
				ST_PREP: begin
					sel_q <= SEL_N;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					step_q <= 5'(LOG_FRAC - 1);
					state_q <= stat.undef ? ST_EMIT : ST_ITER;
				end
				ST_ITER: begin
					step_q <= step_q - 5'd1;
					if (step_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (sel_q == SEL_B) begin
						state_q <= ST_EMIT;
					end else begin
						sel_q <= sel_q + 2'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					busy <= 1'b0;
					done <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/k2p_pair_distance.sv
// ----------------------------------------------------------------------------
// k2p_pair_distance
// Kimura two-parameter distance of one aligned sequence pair.
// ----------------------------------------------------------------------------
// One column word is taken per cycle at an edge where start is high and busy
// is low. Transition and transversion counts are kept per pair. The word with
// last set ends the pair: busy rises and the block evaluates three base-2
// logarithms in turn on one shared squaring unit, each as a load step, one
// squaring iteration per fraction bit and an accumulate step. If a log
// argument is not positive, they are skipped and the pair ends after setup.
// The result word is shown for exactly one cycle with done high; the receiver
// cannot stall it, and a new column word can be taken in that same cycle.
// Counts clear as the result is issued. align_length is written through
// cfg_we and cfg_wdata and should change only while the block is idle.
// Reset clears the counts, sets align_length to one and drops busy and done.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k2p_pair_distance_defines.svh"

module k2p_pair_distance
	import k2p_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             done,
	output result_t          result
);

	cmd_t  cmd;
	stat_t stat;

	k2p_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.last   (item.last),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	k2p_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	`K2P_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`K2P_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`K2P_ASSERT_IMPL(a_undef_sat, clk, arst_n, done && result.undefined, result.distance == DIST_MAX)

endmodule

`default_nettype wire
